[src/fjsp_pkg.sv]
// shared types, phase codes and result kinds for the json string-pair parser
`default_nettype none

package fjsp_pkg;

    // parse phase codes
    typedef logic [3:0] t_phase;

    localparam t_phase PH_OPEN      = 4'd0;
    localparam t_phase PH_KEY_CLOSE = 4'd1;
    localparam t_phase PH_STRING    = 4'd2;
    localparam t_phase PH_ESCAPE    = 4'd3;
    localparam t_phase PH_HEX       = 4'd4;
    localparam t_phase PH_COLON     = 4'd5;
    localparam t_phase PH_VALUE     = 4'd6;
    localparam t_phase PH_AFTER_VAL = 4'd7;
    localparam t_phase PH_DONE      = 4'd8;

    // result kinds
    typedef logic [2:0] t_kind;

    localparam t_kind K_KEY_CHAR = 3'd0;
    localparam t_kind K_VAL_CHAR = 3'd1;
    localparam t_kind K_KEY_END  = 3'd2;
    localparam t_kind K_PAIR_END = 3'd3;
    localparam t_kind K_OK       = 3'd4;
    localparam t_kind K_ERROR    = 3'd5;

    // input item functions
    localparam logic FN_CHAR = 1'b0;
    localparam logic FN_EOT  = 1'b1;

    // byte order mark treated as whitespace
    localparam logic [15:0] CU_BOM = 16'hFEFF;

    // parser state carried from item to item
    typedef struct packed {
        t_phase      phase;
        logic        in_value;
        logic [15:0] hex_accum;
        logic [1:0]  hex_cnt;
    } t_state;

    // one result item
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] ch;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:     PH_OPEN,
        in_value:  1'b0,
        hex_accum: 16'h0000,
        hex_cnt:   2'd0
    };

    // whitespace between tokens
    function automatic logic is_space(input logic [15:0] c);
        is_space = (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000D) ||
                   (c == 16'h000A) || (c == CU_BOM);
    endfunction

endpackage

`default_nettype wire

[src/fjsp_step.sv]
// next-state and result logic for one code unit or end-of-text item
`default_nettype none

module fjsp_step (
    input  wire logic            i_func,
    input  wire logic [15:0]     i_code_unit,
    input  wire fjsp_pkg::t_state i_state,
    output fjsp_pkg::t_state     o_state,
    output fjsp_pkg::t_result    o_result
);

    logic        is_ws;
    logic        is_dec;
    logic        is_lo_hex;
    logic        is_up_hex;
    logic [3:0]  hex_digit;
    logic [15:0] hex_next;
    fjsp_pkg::t_kind text_kind;

    // character classes
    assign is_ws     = fjsp_pkg::is_space(i_code_unit);
    assign is_dec    = (i_code_unit >= 16'h0030) && (i_code_unit <= 16'h0039);
    assign is_lo_hex = (i_code_unit >= 16'h0061) && (i_code_unit <= 16'h0066);
    assign is_up_hex = (i_code_unit >= 16'h0041) && (i_code_unit <= 16'h0046);
    assign hex_digit = is_dec ? i_code_unit[3:0] : (i_code_unit[3:0] + 4'd9);
    assign hex_next  = {i_state.hex_accum[11:0], hex_digit};
    assign text_kind = i_state.in_value ? fjsp_pkg::K_VAL_CHAR : fjsp_pkg::K_KEY_CHAR;

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, kind: fjsp_pkg::K_ERROR, ch: 16'h0000};

        if (i_func == fjsp_pkg::FN_EOT) begin
            // restart; early end of text is an error
            o_state = fjsp_pkg::STATE_RESET;
            if (!i_state.phase[3]) begin
                o_result.valid = 1'b1;
                o_result.kind  = fjsp_pkg::K_ERROR;
            end
        end else begin
            unique case (i_state.phase)
                fjsp_pkg::PH_OPEN: begin
                    if (!is_ws) begin
                        if (i_code_unit == 16'h007B) begin
                            o_state.phase = fjsp_pkg::PH_KEY_CLOSE;
                        end else begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                        end
                    end
                end
                fjsp_pkg::PH_KEY_CLOSE: begin
                    if (!is_ws) begin
                        if (i_code_unit == 16'h007D) begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                            o_result.kind  = fjsp_pkg::K_OK;
                        end else if (i_code_unit == 16'h0022) begin
                            o_state.in_value = 1'b0;
                            o_state.phase    = fjsp_pkg::PH_STRING;
                        end else begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                        end
                    end
                end
                fjsp_pkg::PH_STRING: begin
                    if (i_code_unit == 16'h0022) begin
                        // closing quote of key or value
                        o_result.valid = 1'b1;
                        if (i_state.in_value) begin
                            o_state.phase = fjsp_pkg::PH_AFTER_VAL;
                            o_result.kind = fjsp_pkg::K_PAIR_END;
                        end else begin
                            o_state.phase = fjsp_pkg::PH_COLON;
                            o_result.kind = fjsp_pkg::K_KEY_END;
                        end
                    end else if (i_code_unit == 16'h005C) begin
                        o_state.phase = fjsp_pkg::PH_ESCAPE;
                    end else begin
                        o_result.valid = 1'b1;
                        o_result.kind  = text_kind;
                        o_result.ch    = i_code_unit;
                    end
                end
                fjsp_pkg::PH_ESCAPE: begin
                    if (i_code_unit == 16'h0075) begin
                        o_state.hex_accum = 16'h0000;
                        o_state.hex_cnt   = 2'd0;
                        o_state.phase     = fjsp_pkg::PH_HEX;
                    end else begin
                        o_state.phase  = fjsp_pkg::PH_STRING;
                        o_result.valid = 1'b1;
                        o_result.kind  = text_kind;
                        case (i_code_unit)
                            16'h006E: o_result.ch = 16'h000A;
                            16'h0072: o_result.ch = 16'h000D;
                            16'h0074: o_result.ch = 16'h0009;
                            default:  o_result.ch = i_code_unit;
                        endcase
                    end
                end
                fjsp_pkg::PH_HEX: begin
                    if (is_dec || is_lo_hex || is_up_hex) begin
                        o_state.hex_accum = hex_next;
                        o_state.hex_cnt   = i_state.hex_cnt + 2'd1;
                        if (i_state.hex_cnt == 2'd3) begin
                            // fourth digit completes the code unit
                            o_state.phase  = fjsp_pkg::PH_STRING;
                            o_result.valid = 1'b1;
                            o_result.kind  = text_kind;
                            o_result.ch    = hex_next;
                        end
                    end else begin
                        o_state.phase  = fjsp_pkg::PH_DONE;
                        o_result.valid = 1'b1;
                    end
                end
                fjsp_pkg::PH_COLON: begin
                    if (!is_ws) begin
                        if (i_code_unit == 16'h003A) begin
                            o_state.phase = fjsp_pkg::PH_VALUE;
                        end else begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                        end
                    end
                end
                fjsp_pkg::PH_VALUE: begin
                    if (!is_ws) begin
                        if (i_code_unit == 16'h0022) begin
                            o_state.in_value = 1'b1;
                            o_state.phase    = fjsp_pkg::PH_STRING;
                        end else begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                        end
                    end
                end
                fjsp_pkg::PH_AFTER_VAL: begin
                    if (!is_ws) begin
                        if (i_code_unit == 16'h002C) begin
                            o_state.phase = fjsp_pkg::PH_KEY_CLOSE;
                        end else if (i_code_unit == 16'h007D) begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                            o_result.kind  = fjsp_pkg::K_OK;
                        end else begin
                            o_state.phase  = fjsp_pkg::PH_DONE;
                            o_result.valid = 1'b1;
                        end
                    end
                end
                default: begin
                    // finished: ignore code units until end of text
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/flat_json_string_pair_parser.sv]
// top level: input register, parser step and result register
`default_nettype none

// Streaming parser for a flat JSON object of string-to-string pairs, fed one
// UTF-16 code unit per transfer plus an end-of-text item that restarts it.
// Each item is captured in an input register, run through one step of the
// parser state machine and, if it yields a result, lands in the output
// register; one item is taken per clock unless an item holding a result
// waits on a full output register. Items that yield nothing (whitespace,
// quotes opening a string, escape prefixes) move on even while a result is
// stalled at the output; an item that yields a result waits only for the
// output register to empty. Whitespace includes the byte order mark;
// \n, \r, \t and \uXXXX are decoded, other escapes pass as is; after the
// verdict (ok or one error) code units are dropped until end of text.

module flat_json_string_pair_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic [15:0] i_code_unit,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_char_out
);

    logic                r_in_valid;
    logic                r_func;
    logic [15:0]         r_code_unit;
    fjsp_pkg::t_state    r_state;
    fjsp_pkg::t_state    n_state;
    fjsp_pkg::t_result   step_result;
    logic                r_out_valid;
    fjsp_pkg::t_kind     r_kind;
    logic [15:0]         r_char_out;
    logic                out_free;
    logic                advance;

    // parser step
    fjsp_step u_step (
        .i_func      (r_func),
        .i_code_unit (r_code_unit),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (step_result)
    );

    // flow control between the two registers
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!step_result.valid || out_free);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func      <= i_func;
            r_code_unit <= i_code_unit;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fjsp_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && step_result.valid) begin
            r_kind     <= step_result.kind;
            r_char_out <= step_result.ch;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_char_out  = r_char_out;

endmodule

`default_nettype wire

[src/fjsp_checker.sv]
// port-level checks for the json string-pair parser, bound to the top level
`default_nettype none

module fjsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_kind,
    input wire logic [15:0] o_char_out
);

    // a stalled result keeps its kind and character
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_char_out))
        else $error("result changed while stalled");

    // only key and value characters carry a character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != fjsp_pkg::K_KEY_CHAR) &&
            (o_kind != fjsp_pkg::K_VAL_CHAR) |-> o_char_out == 16'h0000)
        else $error("nonzero character on a mark or verdict");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // with the output free the block never refuses a transfer
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind flat_json_string_pair_parser fjsp_checker u_fjsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_char_out  (o_char_out)
);

`default_nettype wire
